### design/dbs_pkg.sv
// ----------------------------------------------------------------------------
// dbs_pkg
// shared types and constants of the damped resonator bell synthesiser
// ----------------------------------------------------------------------------
package dbs_pkg;

   // default sizes of the resonator bank
   localparam int MAX_BELLS_DEFAULT          = 16;
   localparam int HARMONICS_PER_BELL_DEFAULT = 5;
   localparam int FRACTION_BITS_DEFAULT      = 30;

   // fixed field widths
   localparam int WORD_W      = 32;
   localparam int SAMPLE_W    = 16;
   localparam int CFG_W       = 5;
   localparam int REQ_TDATA_W = 48;
   localparam int REQ_TUSER_W = 4;
   localparam int RSP_TUSER_W = 3;

   // output gain applied to the summed resonators
   localparam int OUTPUT_SCALE = 1000;
   localparam int SCALE_BITS   = 11;

   localparam logic [CFG_W-1:0] ACTIVE_BELLS_RESET = 5'd8;

   typedef enum logic [1:0] {
      OP_TICK   = 2'd0,
      OP_STRIKE = 2'd1,
      OP_LOAD   = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      SEL_COSINE      = 2'd0,
      SEL_DECAY       = 2'd1,
      SEL_STRIKE_NOW  = 2'd2,
      SEL_STRIKE_PREV = 2'd3
   } sel_type;

   typedef enum logic [1:0] {
      ST_SAMPLE = 2'd0,
      ST_STRIKE = 2'd1,
      ST_LOAD   = 2'd2,
      ST_REJECT = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_TICK,
      S_TICK_WAIT,
      S_SCALE,
      S_ROUND,
      S_STRIKE,
      S_STRIKE_WAIT,
      S_LOAD_RD,
      S_LOAD_WR,
      S_DONE
   } state_type;

   // tag that travels beside an entry address through the update pipeline
   typedef struct packed {
      logic valid;
      logic last;
   } pipe_ctl_type;

endpackage

### design/damped_resonator_bell_synth_unit.sv
// ----------------------------------------------------------------------------
// damped_resonator_bell_synth_unit
// modal bell synthesiser: a bank of decaying two-term cosine resonators
// ----------------------------------------------------------------------------
// Each bell owns HARMONICS_PER_BELL resonators, MAX_BELLS * HARMONICS_PER_BELL
// entries in all. The now/prev words live in one ram and the four coefficient
// words (cosine, decay, strike now, strike prev) in a second one, all in
// signed fixed point with FRACTION_BITS fraction bits. One request transfer
// gives exactly one response transfer. A tick walks every entry through a
// four-stage update pipeline, one entry per cycle, and returns the summed
// output times 1000, scaled down toward zero and clipped to 16 bits. A strike
// copies the strike words of the bell's entries into the resonator state, one
// entry per cycle; a load rewrites one coefficient word by a read and write of
// the coefficient ram. Strikes at or beyond min(active_bells, MAX_BELLS),
// loads beyond the bank and operation code 3 change nothing and report
// status 3. One item is worked on at a time; a new request is taken while
// the previous response still waits in the output register. After reset a
// clearing pass zeroes both rams, one entry per cycle, with req_tready low.
// active_bells is written through csr_wr_en / csr_wr_data; the user must
// write it only while idle, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module damped_resonator_bell_synth_unit
   import dbs_pkg::*;
#(
   parameter int MAX_BELLS          = MAX_BELLS_DEFAULT,
   parameter int HARMONICS_PER_BELL = HARMONICS_PER_BELL_DEFAULT,
   parameter int FRACTION_BITS      = FRACTION_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // bell_index[3:0], resonator_index[10:4], coefficient_value[42:11], zero fill
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // operation[1:0], coefficient_select[3:2]
   input  logic [REQ_TUSER_W-1:0] req_tuser,
   // response channel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // sample[15:0]
   output logic [SAMPLE_W-1:0]    rsp_tdata,
   // status[1:0], saturated[2]
   output logic [RSP_TUSER_W-1:0] rsp_tuser,
   // configuration: active_bells
   input  logic                   csr_wr_en,
   input  logic [CFG_W-1:0]       csr_wr_data
);

   localparam int RES_COUNT = MAX_BELLS * HARMONICS_PER_BELL;
   localparam int AW        = (RES_COUNT > 1) ? $clog2(RES_COUNT) : 1;
   localparam int HW        = (HARMONICS_PER_BELL > 1) ? $clog2(HARMONICS_PER_BELL) : 1;
   localparam int SUM_W     = WORD_W + AW + 1;
   localparam int SCALE_W   = SUM_W + SCALE_BITS;
   localparam int STATE_W   = 2 * WORD_W;
   localparam int COEF_W    = 4 * WORD_W;

   localparam logic [AW-1:0] LAST_ADDR = AW'(RES_COUNT - 1);
   localparam logic [HW-1:0] LAST_HARM = HW'(HARMONICS_PER_BELL - 1);
   localparam logic signed [SCALE_W-1:0] SCALE_K = SCALE_W'(OUTPUT_SCALE);

   // request field positions
   localparam int BELL_LSB = 0;
   localparam int RES_LSB  = 4;
   localparam int VAL_LSB  = 11;

   // ---- request fields
   op_type                  req_op;
   logic [3:0]              req_bell;
   logic [6:0]              req_res;
   logic [1:0]              req_sel;
   logic signed [WORD_W-1:0] req_val;
   logic                    req_xfer;
   logic                    bell_ok;
   logic                    res_ok;

   assign req_op   = op_type'(req_tuser[1:0]);
   assign req_sel  = req_tuser[3:2];
   assign req_bell = req_tdata[BELL_LSB +: 4];
   assign req_res  = req_tdata[RES_LSB +: 7];
   assign req_val  = req_tdata[VAL_LSB +: WORD_W];
   assign req_xfer = req_tvalid && req_tready;

   // ---- registers
   state_type                state_ff, state_in;
   logic [AW-1:0]            addr_ff, addr_in;
   logic [HW-1:0]            harm_ff, harm_in;
   logic [CFG_W-1:0]         active_bells_ff, active_bells_in;
   logic [AW-1:0]            load_addr_ff, load_addr_in;
   logic [1:0]               sel_ff, sel_in;
   logic signed [WORD_W-1:0] val_ff, val_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic signed [SCALE_W-1:0] scaled_ff, scaled_in;
   logic [SAMPLE_W-1:0]      res_sample_ff, res_sample_in;
   status_type               res_status_ff, res_status_in;
   logic                     res_sat_ff, res_sat_in;
   pipe_ctl_type             strike_ctl_ff, strike_ctl_in;
   logic [AW-1:0]            strike_addr_ff, strike_addr_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0]      rsp_data_ff, rsp_data_in;
   logic [RSP_TUSER_W-1:0]   rsp_user_ff, rsp_user_in;

   // strike limit is min(active_bells, MAX_BELLS)
   assign bell_ok = (32'(req_bell) < MAX_BELLS) && (32'(req_bell) < 32'(active_bells_ff));
   assign res_ok  = 32'(req_res) < RES_COUNT;

   // ---- ram ports
   logic               state_wr_en, state_rd_en;
   logic [AW-1:0]      state_wr_addr, state_rd_addr;
   logic [STATE_W-1:0] state_wr_data, state_rd_data;
   logic               coef_wr_en, coef_rd_en;
   logic [AW-1:0]      coef_wr_addr, coef_rd_addr;
   logic [COEF_W-1:0]  coef_wr_data, coef_rd_data, coef_merged;

   // ---- update pipeline
   pipe_ctl_type             tick_ctl;
   pipe_ctl_type             wb_ctl;
   logic [AW-1:0]            wb_addr;
   logic signed [WORD_W-1:0] wb_now, wb_prev;

   logic out_free;
   logic round_neg;
   logic [SCALE_W-1:0] round_mag;
   logic [SCALE_W-1:0] round_q;

   // output register can take a new response this cycle
   assign out_free = !rsp_valid_ff || rsp_tready;

   // ---- next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (addr_ff == LAST_ADDR) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_xfer) begin
               unique case (req_op)
                  OP_TICK:   state_in = S_TICK;
                  OP_STRIKE: state_in = bell_ok ? S_STRIKE : S_DONE;
                  OP_LOAD:   state_in = res_ok ? S_LOAD_RD : S_DONE;
                  OP_NONE:   state_in = S_DONE;
                  default:   state_in = S_DONE;
               endcase
            end
         end
         S_TICK: begin
            if (addr_ff == LAST_ADDR) state_in = S_TICK_WAIT;
         end
         S_TICK_WAIT: begin
            if (wb_ctl.valid && wb_ctl.last) state_in = S_SCALE;
         end
         S_SCALE:       state_in = S_ROUND;
         S_ROUND:       state_in = S_DONE;
         S_STRIKE: begin
            if (harm_ff == LAST_HARM) state_in = S_STRIKE_WAIT;
         end
         S_STRIKE_WAIT: begin
            if (strike_ctl_ff.valid && strike_ctl_ff.last) state_in = S_DONE;
         end
         S_LOAD_RD:     state_in = S_LOAD_WR;
         S_LOAD_WR:     state_in = S_DONE;
         S_DONE: begin
            if (out_free) state_in = S_IDLE;
         end
         default:       state_in = S_CLEAR;
      endcase
   end

   // ---- coefficient word merge for a load
   always_comb begin
      coef_merged = coef_rd_data;
      unique case (sel_type'(sel_ff))
         SEL_COSINE:      coef_merged[0*WORD_W +: WORD_W] = val_ff;
         SEL_DECAY:       coef_merged[1*WORD_W +: WORD_W] = val_ff;
         SEL_STRIKE_NOW:  coef_merged[2*WORD_W +: WORD_W] = val_ff;
         SEL_STRIKE_PREV: coef_merged[3*WORD_W +: WORD_W] = val_ff;
         default:         coef_merged = coef_rd_data;
      endcase
   end

   // ---- state machine outputs: ram ports and pipeline issue
   always_comb begin
      req_tready    = 1'b0;
      state_rd_en   = 1'b0;
      state_rd_addr = addr_ff;
      coef_rd_en    = 1'b0;
      coef_rd_addr  = addr_ff;
      coef_wr_en    = 1'b0;
      coef_wr_addr  = addr_ff;
      coef_wr_data  = '0;
      tick_ctl      = '0;
      strike_ctl_in = '0;
      unique case (state_ff)
         S_CLEAR: begin
            coef_wr_en = 1'b1;
         end
         S_IDLE: begin
            req_tready = 1'b1;
         end
         S_TICK: begin
            state_rd_en    = 1'b1;
            coef_rd_en     = 1'b1;
            tick_ctl.valid = 1'b1;
            tick_ctl.last  = (addr_ff == LAST_ADDR);
         end
         S_STRIKE: begin
            coef_rd_en          = 1'b1;
            strike_ctl_in.valid = 1'b1;
            strike_ctl_in.last  = (harm_ff == LAST_HARM);
         end
         S_LOAD_RD: begin
            coef_rd_en   = 1'b1;
            coef_rd_addr = load_addr_ff;
         end
         S_LOAD_WR: begin
            coef_wr_en   = 1'b1;
            coef_wr_addr = load_addr_ff;
            coef_wr_data = coef_merged;
         end
         S_TICK_WAIT, S_SCALE, S_ROUND, S_STRIKE_WAIT, S_DONE: begin
         end
         default: begin
         end
      endcase
   end

   // resonator state write: clearing pass, tick write-back or strike copy
   always_comb begin
      state_wr_en   = 1'b0;
      state_wr_addr = addr_ff;
      state_wr_data = '0;
      priority if (state_ff == S_CLEAR) begin
         state_wr_en = 1'b1;
      end else if (wb_ctl.valid) begin
         state_wr_en   = 1'b1;
         state_wr_addr = wb_addr;
         state_wr_data = {wb_prev, wb_now};
      end else if (strike_ctl_ff.valid) begin
         state_wr_en   = 1'b1;
         state_wr_addr = strike_addr_ff;
         // prev from strike prev, now from strike now
         state_wr_data = {coef_rd_data[3*WORD_W +: WORD_W], coef_rd_data[2*WORD_W +: WORD_W]};
      end else begin
         state_wr_en = 1'b0;
      end
   end

   assign strike_addr_in = addr_ff;

   // ---- final scaling: truncate toward zero and clip to 16 bits
   assign round_neg = scaled_ff[SCALE_W-1];
   assign round_mag = round_neg ? SCALE_W'(-scaled_ff) : SCALE_W'(scaled_ff);
   assign round_q   = round_mag >> FRACTION_BITS;

   // ---- datapath next values
   always_comb begin
      addr_in         = addr_ff;
      harm_in         = harm_ff;
      active_bells_in = active_bells_ff;
      load_addr_in    = load_addr_ff;
      sel_in          = sel_ff;
      val_in          = val_ff;
      sum_in          = sum_ff;
      scaled_in       = scaled_ff;
      res_sample_in   = res_sample_ff;
      res_status_in   = res_status_ff;
      res_sat_in      = res_sat_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_data_in     = rsp_data_ff;
      rsp_user_in     = rsp_user_ff;

      if (csr_wr_en) begin
         active_bells_in = csr_wr_data;
      end

      if (state_ff == S_CLEAR || state_ff == S_TICK || state_ff == S_STRIKE) begin
         addr_in = addr_ff + AW'(1);
         harm_in = harm_ff + HW'(1);
      end

      if (req_xfer) begin
         addr_in       = (req_op == OP_STRIKE) ? AW'(32'(req_bell) * HARMONICS_PER_BELL) : '0;
         harm_in       = '0;
         load_addr_in  = AW'(req_res);
         sel_in        = req_sel;
         val_in        = req_val;
         sum_in        = '0;
         res_sample_in = '0;
         res_sat_in    = 1'b0;
         unique case (req_op)
            OP_TICK:   res_status_in = ST_SAMPLE;
            OP_STRIKE: res_status_in = bell_ok ? ST_STRIKE : ST_REJECT;
            OP_LOAD:   res_status_in = res_ok ? ST_LOAD : ST_REJECT;
            OP_NONE:   res_status_in = ST_REJECT;
            default:   res_status_in = ST_REJECT;
         endcase
      end

      // accumulate each new resonator output as it is written back
      if (wb_ctl.valid) begin
         sum_in = sum_ff + SUM_W'(wb_now);
      end

      if (state_ff == S_SCALE) begin
         scaled_in = SCALE_W'(sum_ff) * SCALE_K;
      end

      if (state_ff == S_ROUND) begin
         if (!round_neg && round_q > SCALE_W'(32767)) begin
            res_sample_in = 16'h7fff;
            res_sat_in    = 1'b1;
         end else if (round_neg && round_q > SCALE_W'(32768)) begin
            res_sample_in = 16'h8000;
            res_sat_in    = 1'b1;
         end else begin
            res_sample_in = round_neg ? SAMPLE_W'(-round_q) : round_q[SAMPLE_W-1:0];
            res_sat_in    = 1'b0;
         end
      end

      // output register
      if (state_ff == S_DONE && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_sample_ff;
         rsp_user_in  = {res_sat_ff, res_status_ff};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // ---- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_CLEAR;
         addr_ff         <= '0;
         harm_ff         <= '0;
         active_bells_ff <= ACTIVE_BELLS_RESET;
         strike_ctl_ff   <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         addr_ff         <= addr_in;
         harm_ff         <= harm_in;
         active_bells_ff <= active_bells_in;
         strike_ctl_ff   <= strike_ctl_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      load_addr_ff   <= load_addr_in;
      sel_ff         <= sel_in;
      val_ff         <= val_in;
      sum_ff         <= sum_in;
      scaled_ff      <= scaled_in;
      res_sample_ff  <= res_sample_in;
      res_status_ff  <= res_status_in;
      res_sat_ff     <= res_sat_in;
      strike_addr_ff <= strike_addr_in;
      rsp_data_ff    <= rsp_data_in;
      rsp_user_ff    <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // ---- memories
   // resonator state: now[31:0], prev[63:32]
   dbs_ram #(
      .WIDTH (STATE_W),
      .DEPTH (RES_COUNT)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (state_wr_en),
      .wr_addr (state_wr_addr),
      .wr_data (state_wr_data),
      .rd_en   (state_rd_en),
      .rd_addr (state_rd_addr),
      .rd_data (state_rd_data)
   );

   // coefficients: cosine, decay, strike now, strike prev from the low word up
   dbs_ram #(
      .WIDTH (COEF_W),
      .DEPTH (RES_COUNT)
   ) u_coef_ram (
      .clock   (clock),
      .wr_en   (coef_wr_en),
      .wr_addr (coef_wr_addr),
      .wr_data (coef_wr_data),
      .rd_en   (coef_rd_en),
      .rd_addr (coef_rd_addr),
      .rd_data (coef_rd_data)
   );

   // ---- resonator update pipeline
   dbs_resonator_pipe #(
      .FRACTION_BITS (FRACTION_BITS),
      .ADDR_W        (AW)
   ) u_pipe (
      .clock   (clock),
      .reset   (reset),
      .in_ctl  (tick_ctl),
      .in_addr (addr_ff),
      .now     (state_rd_data[0*WORD_W +: WORD_W]),
      .prev    (state_rd_data[1*WORD_W +: WORD_W]),
      .cosine  (coef_rd_data[0*WORD_W +: WORD_W]),
      .decay   (coef_rd_data[1*WORD_W +: WORD_W]),
      .wb_ctl  (wb_ctl),
      .wb_addr (wb_addr),
      .wb_now  (wb_now),
      .wb_prev (wb_prev)
   );

endmodule

### design/dbs_ram.sv
// ----------------------------------------------------------------------------
// dbs_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module dbs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 80,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/dbs_resonator_pipe.sv
// ----------------------------------------------------------------------------
// dbs_resonator_pipe
// four-stage update of one resonator entry per cycle
// ----------------------------------------------------------------------------
module dbs_resonator_pipe
   import dbs_pkg::*;
#(
   parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT,
   parameter int ADDR_W        = 7
) (
   input  logic                     clock,
   input  logic                     reset,
   // tag and address presented with the ram read; data follows from its registered output
   input  pipe_ctl_type             in_ctl,
   input  logic [ADDR_W-1:0]        in_addr,
   input  logic signed [WORD_W-1:0] now,
   input  logic signed [WORD_W-1:0] prev,
   input  logic signed [WORD_W-1:0] cosine,
   input  logic signed [WORD_W-1:0] decay,
   output pipe_ctl_type             wb_ctl,
   output logic [ADDR_W-1:0]        wb_addr,
   output logic signed [WORD_W-1:0] wb_now,
   output logic signed [WORD_W-1:0] wb_prev
);

   localparam int PROD_W = 2 * WORD_W;

   function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [PROD_W-1:0] v);
      logic signed [PROD_W-1:0] hi;
      logic signed [PROD_W-1:0] lo;
      hi = PROD_W'(32'sh7fffffff);
      lo = PROD_W'(32'sh80000000);
      if (v > hi) begin
         return 32'sh7fffffff;
      end else if (v < lo) begin
         return 32'sh80000000;
      end else begin
         return v[WORD_W-1:0];
      end
   endfunction

   // stage 1: aligned with the ram data
   pipe_ctl_type             ctl1_ff;
   logic [ADDR_W-1:0]        addr1_ff;
   // stage 2: products of the old now
   pipe_ctl_type             ctl2_ff;
   logic [ADDR_W-1:0]        addr2_ff;
   logic signed [PROD_W-1:0] pcos2_ff;
   logic signed [PROD_W-1:0] pdec2_ff;
   logic signed [WORD_W-1:0] prev2_ff;
   logic signed [WORD_W-1:0] decay2_ff;
   // stage 3: next value and new prev
   pipe_ctl_type             ctl3_ff;
   logic [ADDR_W-1:0]        addr3_ff;
   logic signed [WORD_W-1:0] next3_ff;
   logic signed [WORD_W-1:0] nprev3_ff;
   logic signed [WORD_W-1:0] decay3_ff;
   // stage 4: damped next
   pipe_ctl_type             ctl4_ff;
   logic [ADDR_W-1:0]        addr4_ff;
   logic signed [PROD_W-1:0] pnext4_ff;
   logic signed [WORD_W-1:0] nprev4_ff;

   logic signed [PROD_W-1:0] pcos2_in;
   logic signed [PROD_W-1:0] pdec2_in;
   logic signed [PROD_W-1:0] next_wide;
   logic signed [PROD_W-1:0] pnext4_in;

   assign pcos2_in  = now * cosine;
   assign pdec2_in  = now * decay;
   // doubled cosine product: one fraction bit less in the shift
   assign next_wide = (pcos2_ff >>> (FRACTION_BITS - 1)) - PROD_W'(prev2_ff);
   assign pnext4_in = next3_ff * decay3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
         ctl2_ff <= '0;
         ctl3_ff <= '0;
         ctl4_ff <= '0;
      end else begin
         ctl1_ff <= in_ctl;
         ctl2_ff <= ctl1_ff;
         ctl3_ff <= ctl2_ff;
         ctl4_ff <= ctl3_ff;
      end
   end

   always_ff @(posedge clock) begin
      addr1_ff  <= in_addr;
      addr2_ff  <= addr1_ff;
      pcos2_ff  <= pcos2_in;
      pdec2_ff  <= pdec2_in;
      prev2_ff  <= prev;
      decay2_ff <= decay;
      addr3_ff  <= addr2_ff;
      next3_ff  <= sat_word(next_wide);
      nprev3_ff <= sat_word(pdec2_ff >>> FRACTION_BITS);
      decay3_ff <= decay2_ff;
      addr4_ff  <= addr3_ff;
      pnext4_ff <= pnext4_in;
      nprev4_ff <= nprev3_ff;
   end

   assign wb_ctl  = ctl4_ff;
   assign wb_addr = addr4_ff;
   assign wb_now  = sat_word(pnext4_ff >>> FRACTION_BITS);
   assign wb_prev = nprev4_ff;

endmodule

### design/dbs_checker.sv
// ----------------------------------------------------------------------------
// dbs_checker
// port-level checks of the bell synthesiser, bound to the top level
// ----------------------------------------------------------------------------
module dbs_checker
   import dbs_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [SAMPLE_W-1:0]    rsp_tdata,
   input logic [RSP_TUSER_W-1:0] rsp_tuser
);

   // requests taken whose response has not yet been transferred
   logic [1:0] pending_ff;
   logic       in_xfer;
   logic       out_xfer;

   assign in_xfer  = req_tvalid && req_tready;
   assign out_xfer = rsp_tvalid && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_ff + 2'(in_xfer) - 2'(out_xfer);
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   a_non_tick_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1:0] != 2'(ST_SAMPLE) |-> rsp_tdata == '0 && !rsp_tuser[2])
      else $error("non-tick response carries sample or clip flag");

   a_clip_value: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2] |-> rsp_tdata == 16'h7fff || rsp_tdata == 16'h8000)
      else $error("clip flag without a full-scale sample");

   a_rsp_has_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> pending_ff != 2'd0)
      else $error("response without an outstanding request");

   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= 2'd2)
      else $error("more than two requests in flight");

endmodule

bind damped_resonator_bell_synth_unit dbs_checker u_dbs_checker (.*);

### test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the damped resonator bell synthesiser
// ----------------------------------------------------------------------------
// Request transfers come out of a backlog that the stimulus process fills.
// Every accepted request is run through a bit-exact model of the resonator
// bank, and the model's response joins a queue. The response watcher compares
// each response transfer, field by field, with the oldest queued response. A
// short directed run comes first. Random phases follow, each under its own
// active_bells setting. Most of the random traffic programs bells,
// strikes them and lets them ring for a few ticks; the rest is single strikes,
// tick bursts and raw requests with any field value.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import dbs_pkg::*;

   localparam int NUM_BELLS     = MAX_BELLS_DEFAULT;
   localparam int HARMONICS     = HARMONICS_PER_BELL_DEFAULT;
   localparam int FRAC          = FRACTION_BITS_DEFAULT;
   localparam int BANK_SIZE     = NUM_BELLS * HARMONICS;
   localparam int FIELD_BITS    = 4 + 7 + WORD_W;
   localparam int CYCLE_LIMIT   = 500000;
   localparam int SETTLE_CYCLES = 100;
   localparam int IDLE_PERCENT  = 9;
   localparam int PHASE_ITEMS   = 180;

   localparam logic [WORD_W-1:0] WORD_MAX   = 32'h7FFF_FFFF;
   localparam logic [WORD_W-1:0] WORD_MIN   = 32'h8000_0000;
   localparam longint            SAMPLE_HI  = 32767;
   localparam longint            SAMPLE_LO  = -32768;

   // how coefficient words are chosen when a bell is programmed
   typedef enum int {STYLE_MUSICAL, STYLE_EXTREME, STYLE_RANDOM} coef_style_type;

   // one request transfer, plus a flag to hold it back until the bank is drained
   typedef struct {
      op_type              op;
      logic [3:0]          bell;
      logic [6:0]          res;
      sel_type             sel;
      logic [WORD_W-1:0]   value;
      bit                  drain;
   } synth_req_type;

   typedef struct {
      logic [SAMPLE_W-1:0] sample;
      status_type          status;
      logic                saturated;
   } synth_rsp_type;

   // dut connections, all inputs known from time zero
   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_tvalid  = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata   = '0;
   logic [REQ_TUSER_W-1:0] req_tuser   = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready  = 1'b0;
   logic [SAMPLE_W-1:0]    rsp_tdata;
   logic [RSP_TUSER_W-1:0] rsp_tuser;
   logic                   csr_wr_en   = 1'b0;
   logic [CFG_W-1:0]       csr_wr_data = '0;

   // model of the resonator bank and its coefficient store
   logic signed [WORD_W-1:0] osc_now      [BANK_SIZE] = '{default: '0};
   logic signed [WORD_W-1:0] osc_prev     [BANK_SIZE] = '{default: '0};
   logic signed [WORD_W-1:0] cos_tab      [BANK_SIZE] = '{default: '0};
   logic signed [WORD_W-1:0] decay_tab    [BANK_SIZE] = '{default: '0};
   logic signed [WORD_W-1:0] hit_now_tab  [BANK_SIZE] = '{default: '0};
   logic signed [WORD_W-1:0] hit_prev_tab [BANK_SIZE] = '{default: '0};
   int                       bells_enabled = int'(ACTIVE_BELLS_RESET);

   synth_req_type req_backlog [$];
   synth_rsp_type due_responses [$];
   synth_req_type cur_req;

   int items_made  = 0;   // requests queued, ignored operation code left out
   int reqs_sent   = 0;   // request transfers, updated at the clock edge
   int rsps_taken  = 0;   // response transfers, updated at the clock edge
   int fault_count = 0;
   int cycle_count = 0;
   bit steady      = 1'b0; // no idling on either side while set

   damped_resonator_bell_synth_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // bank model
   // ------------------------------------------------------------------------

   // clip a wide intermediate to a signed 32-bit word
   function automatic logic signed [WORD_W-1:0] sat_word(input longint v);
      if (v > 64'sd2147483647) begin
         return WORD_MAX;
      end
      if (v < -64'sd2147483648) begin
         return WORD_MIN;
      end
      return v[WORD_W-1:0];
   endfunction

   // bells that a strike may address under the current setting
   function automatic int strikable_bells();
      return (bells_enabled < NUM_BELLS) ? bells_enabled : NUM_BELLS;
   endfunction

   // advance the model by one request and give the response it owes
   function automatic synth_rsp_type bank_step(input synth_req_type it);
      synth_rsp_type r;
      longint   acc, scaled, q, cur, nxt;
      int       k, h;
      r.sample    = '0;
      r.status    = ST_REJECT;
      r.saturated = 1'b0;
      case (it.op)
         OP_TICK: begin
            acc = 0;
            for (k = 0; k < BANK_SIZE; k++) begin
               cur = osc_now[k];
               // products are floored by the arithmetic shift
               nxt = sat_word(((cur * cos_tab[k]) >>> (FRAC - 1)) - osc_prev[k]);
               osc_prev[k] = sat_word((cur * decay_tab[k]) >>> FRAC);
               osc_now[k]  = sat_word((nxt * decay_tab[k]) >>> FRAC);
               acc += osc_now[k];
            end
            // gain, then a scale-down that rounds toward zero
            scaled = acc * OUTPUT_SCALE;
            q = (scaled >= 0) ? (scaled >>> FRAC) : -((-scaled) >>> FRAC);
            if (q > SAMPLE_HI) begin
               q = SAMPLE_HI;
               r.saturated = 1'b1;
            end
            if (q < SAMPLE_LO) begin
               q = SAMPLE_LO;
               r.saturated = 1'b1;
            end
            r.sample = q[SAMPLE_W-1:0];
            r.status = ST_SAMPLE;
         end
         OP_STRIKE: begin
            if (int'(it.bell) < strikable_bells()) begin
               for (h = 0; h < HARMONICS; h++) begin
                  k = int'(it.bell) * HARMONICS + h;
                  osc_now[k]  = hit_now_tab[k];
                  osc_prev[k] = hit_prev_tab[k];
               end
               r.status = ST_STRIKE;
            end
         end
         OP_LOAD: begin
            if (int'(it.res) < BANK_SIZE) begin
               case (it.sel)
                  SEL_COSINE:     cos_tab[it.res]      = it.value;
                  SEL_DECAY:      decay_tab[it.res]    = it.value;
                  SEL_STRIKE_NOW: hit_now_tab[it.res]  = it.value;
                  default:        hit_prev_tab[it.res] = it.value;
               endcase
               r.status = ST_LOAD;
            end
         end
         default: begin
            // operation code 3 leaves everything alone
         end
      endcase
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // request driver: one transfer in flight, held until accepted
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : req_driver
      bit taken;
      bit offer;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         taken = req_tvalid && req_tready;
         offer = req_tvalid && !taken;
         if (taken) begin
            due_responses = {due_responses, bank_step(cur_req)};
            reqs_sent <= reqs_sent + 1;
         end
         // a flagged request waits until every response so far has come back
         if (!offer && req_backlog.size() != 0
             && !(!steady && $urandom_range(99) < IDLE_PERCENT)
             && !(req_backlog[0].drain && reqs_sent + int'(taken) != rsps_taken)) begin
            cur_req = req_backlog.pop_front();
            offer   = 1'b1;
         end
         req_tvalid <= offer;
         req_tdata  <= {{(REQ_TDATA_W-FIELD_BITS){1'b0}},
                        cur_req.value, cur_req.res, cur_req.bell};
         req_tuser  <= {cur_req.sel, cur_req.op};
      end
   end

   // ------------------------------------------------------------------------
   // response watcher: random back-pressure and field checks
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : rsp_monitor
      synth_rsp_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            rsps_taken <= rsps_taken + 1;
            if (due_responses.size() == 0) begin
               $display("%0t ns: unexpected response, sample %0d status %0d",
                        $time, $signed(rsp_tdata), rsp_tuser[1:0]);
               fault_count++;
            end else begin
               want = due_responses.pop_front();
               if (rsp_tdata !== want.sample) begin
                  $display("%0t ns: sample expected %0d, got %0d",
                           $time, $signed(want.sample), $signed(rsp_tdata));
                  fault_count++;
               end
               if (rsp_tuser[1:0] !== want.status) begin
                  $display("%0t ns: status expected %0d, got %0d",
                           $time, want.status, rsp_tuser[1:0]);
                  fault_count++;
               end
               if (rsp_tuser[2] !== want.saturated) begin
                  $display("%0t ns: saturated expected %0b, got %0b",
                           $time, want.saturated, rsp_tuser[2]);
                  fault_count++;
               end
            end
         end
         rsp_tready <= steady || $urandom_range(99) >= IDLE_PERCENT;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------

   task automatic queue_item(input op_type op, input logic [3:0] bell,
                             input logic [6:0] res, input sel_type sel,
                             input logic [WORD_W-1:0] value, input bit drain = 1'b0);
      synth_req_type it;
      it = '{op, bell, res, sel, value, drain};
      req_backlog = {req_backlog, it};
      if (op != OP_NONE) begin
         items_made++;
      end
   endtask

   // ticks with random don't-care fields
   task automatic tick_burst(input int count);
      int n;
      for (n = 0; n < count; n++) begin
         queue_item(OP_TICK, 4'($urandom_range(15)), 7'($urandom_range(127)),
                    sel_type'($urandom_range(3)), $urandom());
      end
   endtask

   function automatic logic [WORD_W-1:0] pick_coef(input coef_style_type style,
                                                    input sel_type sel, input bit neg);
      longint v;
      case (style)
         STYLE_MUSICAL: begin
            case (sel)
               // cosine within +-1.0, decay 0.95 to 1.0, strike within +-0.25
               SEL_COSINE: v = longint'($urandom_range(32'h8000_0000)) - 64'sd1073741824;
               SEL_DECAY:  v = longint'($urandom_range(32'h4000_0000, 32'h3CCC_CCCD));
               default:    v = longint'($urandom_range(32'h2000_0000)) - 64'sd268435456;
            endcase
         end
         STYLE_EXTREME: begin
            // full-scale words drive every resonator into saturation
            case (sel)
               SEL_STRIKE_NOW:  v = neg ? longint'(signed'(WORD_MIN)) : longint'(WORD_MAX);
               SEL_STRIKE_PREV: v = 0;
               default:         v = longint'(WORD_MAX);
            endcase
         end
         default: v = longint'($urandom());
      endcase
      return v[WORD_W-1:0];
   endfunction

   // program a bell's resonators, strike it and let it ring
   task automatic voice_bell(input int bell, input coef_style_type style, input bit neg,
                             input bit full, input int ticks);
      int h, s;
      for (h = 0; h < HARMONICS; h++) begin
         for (s = 0; s < 4; s++) begin
            if (full || $urandom_range(3) != 0) begin
               queue_item(OP_LOAD, 4'($urandom_range(15)), 7'(bell * HARMONICS + h),
                          sel_type'(s), pick_coef(style, sel_type'(s), neg));
            end
         end
      end
      queue_item(OP_STRIKE, 4'(bell), 7'($urandom_range(127)),
                 sel_type'($urandom_range(3)), $urandom(), $urandom_range(19) == 0);
      tick_burst(ticks);
   endtask

   task automatic compose_phase(input int quota, input bit neg);
      int start, lim, pick, b;
      start = items_made;
      lim   = strikable_bells();
      // loud chorus on four bells so the output clips
      if (lim >= 4) begin
         for (b = 0; b < 4; b++) begin
            voice_bell(b, STYLE_EXTREME, neg, 1'b1, 1);
         end
         tick_burst(4);
      end
      while (items_made - start < quota) begin
         pick = $urandom_range(99);
         if (pick < 45) begin
            b = (lim == 0 || $urandom_range(9) == 0) ? $urandom_range(NUM_BELLS - 1)
                                                     : $urandom_range(lim - 1);
            voice_bell(b, coef_style_type'($urandom_range(2)), $urandom_range(1), 1'b0,
                       $urandom_range(1, 8));
         end else if (pick < 70) begin
            tick_burst($urandom_range(1, 10));
         end else if (pick < 85) begin
            queue_item(OP_STRIKE, 4'($urandom_range(15)), 7'($urandom_range(127)),
                       sel_type'($urandom_range(3)), $urandom());
         end else begin
            // raw request, any operation and any index
            queue_item(op_type'($urandom_range(3)), 4'($urandom_range(15)),
                       7'($urandom_range(127)), sel_type'($urandom_range(3)), $urandom());
         end
      end
   endtask

   // sampled at the falling edge so the edge's own updates have settled
   task automatic wait_drained();
      do begin
         @(negedge clock);
      end while (req_backlog.size() != 0 || req_tvalid || reqs_sent != rsps_taken);
   endtask

   task automatic write_active_bells(input logic [CFG_W-1:0] v);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      bells_enabled = int'(v);
      @(negedge clock);
   endtask

   // drain, change the setting while idle, then queue a random phase
   task automatic run_phase(input logic [CFG_W-1:0] bells, input bit quiet, input bit neg);
      wait_drained();
      write_active_bells(bells);
      steady = quiet;
      compose_phase(PHASE_ITEMS, neg);
   endtask

   initial begin : stimulus
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed run under the reset setting of eight bells
      tick_burst(1);                                            // silent bank
      queue_item(OP_LOAD, 4'h0, 7'd0, SEL_COSINE, WORD_MAX);
      queue_item(OP_LOAD, 4'h0, 7'd0, SEL_DECAY, WORD_MAX);
      queue_item(OP_LOAD, 4'h0, 7'd0, SEL_STRIKE_NOW, WORD_MAX);
      queue_item(OP_LOAD, 4'h0, 7'd0, SEL_STRIKE_PREV, WORD_MIN); // word overflow on tick
      queue_item(OP_LOAD, 4'h0, 7'd79, SEL_COSINE, WORD_MIN);     // last entry of the bank
      queue_item(OP_LOAD, 4'h0, 7'd79, SEL_STRIKE_NOW, 32'h4000_0000);
      queue_item(OP_LOAD, 4'h0, 7'd80, SEL_DECAY, 32'h1234_5678); // just past the bank
      queue_item(OP_LOAD, 4'hF, 7'd127, SEL_STRIKE_PREV, '1);     // top index, all ones
      queue_item(OP_STRIKE, 4'h0, 7'd0, SEL_COSINE, '0, 1'b1);    // after a full drain
      queue_item(OP_STRIKE, 4'h7, 7'd0, SEL_COSINE, '0);          // last bell in range
      queue_item(OP_STRIKE, 4'h8, 7'd0, SEL_COSINE, '0);          // first bell out of range
      queue_item(OP_STRIKE, 4'hF, 7'd127, SEL_STRIKE_PREV, '1);   // out of range, all ones
      queue_item(OP_NONE, 4'hF, 7'd127, SEL_STRIKE_PREV, '1);     // unused operation
      tick_burst(2);
      queue_item(OP_LOAD, 4'h0, 7'd5, SEL_DECAY, '0);             // zero word
      queue_item(OP_LOAD, 4'h0, 7'd0, SEL_DECAY, '1);             // minus one lsb
      tick_burst(2);

      // random phases, the first still under the reset setting
      compose_phase(PHASE_ITEMS, 1'b0);
      run_phase(5'd16, 1'b0, 1'b1);
      run_phase(5'd1, 1'b1, 1'b0);    // single bell, no idling anywhere
      run_phase(5'd31, 1'b0, 1'b0);
      run_phase(5'd0, 1'b0, 1'b1);    // every strike rejected
      run_phase(5'd12, 1'b0, 1'b1);

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fault_count == 0 && due_responses.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
